[rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants, command codes and types of the sorted key store.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TAG_BITS = 16;
  localparam int POS_W    = 10;
  localparam int SLOT_W   = 10;
  localparam int ENTRY_W  = KEY_W + TAG_BITS;

  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 80;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_SLOT  = 1'b1;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    high_key;
    logic [TAG_BITS-1:0] record_tag;
    logic [SLOT_W-1:0]   slot_index;
    logic                last_load;
  } item_t;

  typedef struct packed {
    logic                result_kind;
    logic                first_found;
    logic [POS_W-1:0]    first_position;
    logic                last_found;
    logic [POS_W-1:0]    last_position;
    logic                range_valid;
    logic                slot_valid;
    logic [KEY_W-1:0]    slot_key;
    logic [TAG_BITS-1:0] slot_tag;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             overflow;
  } status_t;

endpackage

[rtl/sks_ram.sv]
// ----------------------------------------------------------------------------
// sks_ram
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module sks_ram #(
  parameter  int WIDTH  = 48,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/sks_ctrl.sv]
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer of the key store: binary search over the RAM, insertion shift,
// slot reads, and assembly of one result per query or read.
// ----------------------------------------------------------------------------
module sks_ctrl
  import sks_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output status_t            status,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic [IDX_W-1:0]   ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRD   = 3'd1;
  localparam logic [2:0] ST_SCMP  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_INS   = 3'd4;
  localparam logic [2:0] ST_RDW   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state;
  item_t            item;
  logic [CNT_W-1:0] count;
  logic             set_complete;
  logic             overflow;

  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic             eq;
  logic             phase;
  logic             ff;
  logic [CNT_W-1:0] f_pos;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] last_rd;
  logic             issuing;
  logic             live;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_c;
  logic [KEY_W-1:0]   v;
  logic               upper;
  logic [KEY_W-1:0]   rkey;
  logic               go_right;
  logic [CNT_W-1:0]   wr_c;
  logic [CNT_W-1:0]   l_pos;
  logic [CNT_W-1:0]   cnt_eff;
  logic               accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign status   = '{entry_count: count, overflow: overflow};

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_c    = mid_sum[CNT_W:1];
  assign v        = phase ? item.high_key : item.key;
  assign upper    = (item.command == CMD_LOAD) || phase;
  assign rkey     = ram_rdata[ENTRY_W-1:TAG_BITS];
  assign go_right = (rkey < v) || (upper && (rkey == v));
  assign wr_c     = last_rd + CNT_W'(1);
  assign l_pos    = lo - CNT_W'(1);
  assign cnt_eff  = set_complete ? '0 : count;

  always_comb begin
    unique case (state)
      ST_SRD:   ram_raddr = mid_c[IDX_W-1:0];
      ST_SHIFT: ram_raddr = rd_ptr[IDX_W-1:0];
      default:  ram_raddr = in_item.slot_index[IDX_W-1:0];
    endcase
  end

  assign ram_we    = ((state == ST_SHIFT) && live) || (state == ST_INS);
  assign ram_waddr = (state == ST_INS) ? lo[IDX_W-1:0] : wr_c[IDX_W-1:0];
  assign ram_wdata = (state == ST_INS) ? {item.key, item.record_tag} : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      set_complete <= 1'b0;
      overflow     <= 1'b0;
      issuing      <= 1'b0;
      live         <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item  <= in_item;
            lo    <= '0;
            eq    <= 1'b0;
            phase <= 1'b0;
            case (in_item.command)
              CMD_LOAD: begin
                if (set_complete) begin
                  count        <= '0;
                  set_complete <= 1'b0;
                  overflow     <= 1'b0;
                end
                hi <= cnt_eff;
                if (cnt_eff == CNT_W'(CAPACITY)) begin
                  // store full: drop the key, still honor the set mark
                  overflow <= 1'b1;
                  if (in_item.last_load) begin
                    set_complete <= 1'b1;
                  end
                end else begin
                  state <= ST_SRD;
                end
              end
              CMD_QUERY: begin
                hi    <= count;
                state <= ST_SRD;
              end
              CMD_READ: begin
                state <= ST_RDW;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        ST_SRD: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= ST_SCMP;
          end else if (item.command == CMD_LOAD) begin
            if (lo == count) begin
              state <= ST_INS;
            end else begin
              rd_ptr  <= count - CNT_W'(1);
              issuing <= 1'b1;
              live    <= 1'b0;
              state   <= ST_SHIFT;
            end
          end else if (!phase) begin
            // lower bound done, start the upper bound search
            ff    <= eq;
            f_pos <= lo;
            phase <= 1'b1;
            lo    <= '0;
            hi    <= count;
            eq    <= 1'b0;
          end else begin
            res.result_kind    <= KIND_QUERY;
            res.first_found    <= ff;
            res.first_position <= ff ? f_pos[POS_W-1:0] : '0;
            res.last_found     <= eq;
            res.last_position  <= eq ? l_pos[POS_W-1:0] : '0;
            res.range_valid    <= ff && eq && (f_pos <= l_pos);
            res.slot_valid     <= 1'b0;
            res.slot_key       <= '0;
            res.slot_tag       <= '0;
            res.overflow       <= overflow;
            state              <= ST_DONE;
          end
        end

        ST_SCMP: begin
          eq <= eq | (rkey == v);
          if (go_right) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_SRD;
        end

        ST_SHIFT: begin
          // read entry i while entry i+2 takes entry i+1, read in the previous cycle
          if (issuing) begin
            last_rd <= rd_ptr;
            live    <= 1'b1;
            if (rd_ptr == lo) begin
              issuing <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr - CNT_W'(1);
            end
          end else begin
            live  <= 1'b0;
            state <= ST_INS;
          end
        end

        ST_INS: begin
          count <= count + CNT_W'(1);
          if (item.last_load) begin
            set_complete <= 1'b1;
          end
          state <= ST_IDLE;
        end

        ST_RDW: begin
          res.result_kind    <= KIND_SLOT;
          res.first_found    <= 1'b0;
          res.first_position <= '0;
          res.last_found     <= 1'b0;
          res.last_position  <= '0;
          res.range_valid    <= 1'b0;
          res.overflow       <= overflow;
          if ({1'b0, item.slot_index} < count) begin
            res.slot_valid <= 1'b1;
            res.slot_key   <= rkey;
            res.slot_tag   <= ram_rdata[TAG_BITS-1:0];
          end else begin
            res.slot_valid <= 1'b0;
            res.slot_key   <= '0;
            res.slot_tag   <= '0;
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sorted_key_store_range_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_store_range_search_top
// Sorted key store with first/last occurrence range search and slot reads.
//
//   channel | dir | tdata fields (low bit up)                     | tuser       | tlast
//   s_      | in  | key, high_key, record_tag, slot_index, pad     | command     | last_load
//   m_      | out | first_found, first_position, last_found,       | result_kind | -
//           |     | last_position, range_valid, slot_valid,        |             |
//           |     | slot_key, slot_tag, overflow, pad              |             |
//
// One item at a time. A search step has a RAM read state and a compare state; a
// query runs a lower bound and an upper bound search, a read one RAM read; a load
// runs a search, then shifts up the entries from the insert position on, one entry
// per cycle, and writes the new entry. A full output register holds the result until
// m_tready. Synchronous reset clears state, count and flags only; RAM words stay
// undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_store_range_search_top
  import sks_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // key, high_key, record_tag, slot_index
  input  logic [1:0]          s_tuser,  // command
  input  logic                s_tlast,  // last_load
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // first_found, first_position, last_found,
                                        // last_position, range_valid, slot_valid,
                                        // slot_key, slot_tag, overflow
  output logic                m_tuser   // result_kind
);

  item_t              in_item;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  status_t            status;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_item = '{
    command:    s_tuser,
    key:        s_tdata[31:0],
    high_key:   s_tdata[63:32],
    record_tag: s_tdata[64 +: TAG_BITS],
    slot_index: s_tdata[89:80],
    last_load:  s_tlast
  };

  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sks_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: take a new result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.result_kind;
      m_tdata <= {7'b0, res.overflow, res.slot_tag, res.slot_key, res.slot_valid,
                  res.range_valid, res.last_position, res.last_found,
                  res.first_position, res.first_found};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    status.overflow |-> (status.entry_count == CNT_W'(CAPACITY)))
    else $error("overflow flag set while store not full");

  a_nop_returns: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_NONE)) |=> s_tready)
    else $error("unused command kept the block busy");

endmodule
